[rtl/fpfa_pkg.sv]
// Shared types and constants for the fixed partition fit allocator.
package fpfa_pkg;

  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 4;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST_FIT = 2'd0,
    CMD_BEST_FIT  = 2'd1,
    CMD_FREE      = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

[rtl/fixed_partition_fit_allocator.sv]
// Fixed partition allocator: first-fit, best-fit and free over configured partitions.
//
// A command is taken when start_i is high and busy_o is low. The block then
// walks the partitions one per cycle through a shared datapath, in the scan
// state. A finishing state then commits the free flag and loads the result
// registers, and the result is shown in the cycle after it, for exactly one
// cycle with done_o high; the receiver cannot stall it, and busy_o is already
// low in that cycle, so the next command may be started at the same edge
// that takes the result. Partition sizes are written through the
// configuration channel, which is always ready; writes must only be made
// while no command is in flight, and the block itself does not enforce this.
// A size of zero marks an absent partition. Writes to an index at or beyond
// NUM_PARTS are dropped. After reset every partition is free and every size
// is zero.
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int unsigned NUM_PARTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command channel.
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [SIZE_W-1:0]    request_size_i,
  input  logic [ID_W-1:0]      target_id_i,
  // Result channel.
  output logic                 done_o,
  output logic                 ok_o,
  output logic [ID_W-1:0]      granted_id_o,
  output logic [SIZE_W-1:0]    granted_size_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTS - 1);

  state_e state_q, state_d;

  size_t part_size_q [NUM_PARTS];
  logic [NUM_PARTS-1:0] free_q;

  // Latched command.
  cmd_e  cmd_q;
  size_t need_q;
  id_t   tid_q;

  // Scan state.
  logic [IDX_W-1:0] idx_q;
  logic             found_q;
  logic [IDX_W-1:0] pick_q;
  size_t            best_q;

  // Result registers.
  logic  done_q;
  logic  ok_q;
  id_t   id_q;
  size_t rsize_q;

  logic  accept;
  logic  cfg_fire;
  size_t cur_size;
  logic  cur_free;
  logic  present;
  logic  fits;
  logic  smaller;
  logic  id_hit;
  logic  take;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // The shared datapath: one partition read, one fit compare, one size compare.
  assign cur_size = part_size_q[idx_q];
  assign cur_free = free_q[idx_q];
  assign present  = (cur_size != '0);
  assign fits     = (cur_size >= need_q);
  assign smaller  = (cur_size < best_q);
  assign id_hit   = (tid_q == (ID_W'(idx_q) + ID_W'(1)));

  always_comb begin
    unique case (cmd_q)
      CMD_FIRST_FIT: take = present && cur_free && fits && !found_q;
      CMD_BEST_FIT:  take = present && cur_free && fits && (!found_q || smaller);
      CMD_FREE:      take = present && id_hit;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == LAST_IDX) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      free_q  <= '1;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FINISH);
      if (accept) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (idx_q != LAST_IDX) idx_q <= idx_q + IDX_W'(1);
        if (take) found_q <= 1'b1;
      end else if (state_q == ST_FINISH && found_q) begin
        // Allocation claims the partition, free releases it.
        free_q[pick_q] <= (cmd_q == CMD_FREE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PARTS; i++) part_size_q[i] <= '0;
    end else if (cfg_fire) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(i)) part_size_q[i] <= cfg_data_i;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      need_q <= request_size_i;
      tid_q  <= target_id_i;
    end
    if (state_q == ST_SCAN && take) begin
      pick_q <= idx_q;
      best_q <= cur_size;
    end
    if (state_q == ST_FINISH) begin
      ok_q    <= found_q;
      id_q    <= found_q ? (ID_W'(pick_q) + ID_W'(1)) : '0;
      rsize_q <= found_q ? best_q : '0;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign granted_id_o   = id_q;
  assign granted_size_o = rsize_q;

  a_done_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("result strobe without a finishing cycle");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (granted_id_o == '0 && granted_size_o == '0))
    else $error("failed result carries nonzero fields");

  a_ok_id_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ok_o) |-> (granted_id_o != '0 && granted_id_o <= ID_W'(NUM_PARTS)))
    else $error("granted id out of range");

  a_alloc_claims : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && found_q && cmd_q != CMD_FREE) |=> !free_q[$past(pick_q)])
    else $error("allocation did not claim its partition");

endmodule

[tb/fixed_partition_fit_allocator_tb.sv]
// Self-checking regression for the fixed partition fit allocator.
module fixed_partition_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpfa_pkg::*;

  localparam int unsigned NUM_PARTS    = 8;
  // About 1800 commands are sent in all, which fit well inside this bound.
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RAND_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS  = 250;

  // One expected result: the outcome of one command.
  typedef struct packed {
    logic  ok;
    id_t   id;
    size_t size;
  } grant_t;

  // Mirrors the partition sizes and free flags. Each accepted command is
  // resolved against the mirror at once, and its grant waits in a queue
  // until the block reports it.
  class partition_ledger;
    size_t  part_size[NUM_PARTS];
    bit     part_free[NUM_PARTS];
    grant_t pending_grants[$];
    int     mismatches;

    function new();
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_size[i] = '0;
        part_free[i] = 1'b1;
      end
      mismatches = 0;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, size_t value);
      if (idx < NUM_PARTS) begin
        part_size[idx] = value;
      end
    endfunction

    function bit fits(int i, size_t need);
      return part_size[i] != '0 && part_free[i] && part_size[i] >= need;
    endfunction

    function void note_request(cmd_e cmd, size_t need, id_t tid);
      grant_t g;
      int     pick;
      g    = '0;
      pick = -1;
      case (cmd)
        CMD_FIRST_FIT: begin
          for (int i = 0; i < NUM_PARTS; i++) begin
            if (pick < 0 && fits(i, need)) pick = i;
          end
        end
        CMD_BEST_FIT: begin
          // Strictly smaller wins, so the lowest id keeps a tie.
          for (int i = 0; i < NUM_PARTS; i++) begin
            if (fits(i, need) && (pick < 0 || part_size[i] < part_size[pick])) pick = i;
          end
        end
        CMD_FREE: begin
          if (tid >= 1 && tid <= NUM_PARTS && part_size[tid-1] != '0) pick = tid - 1;
        end
        default: ;
      endcase
      if (pick >= 0) begin
        part_free[pick] = (cmd == CMD_FREE);
        g.ok   = 1'b1;
        g.id   = id_t'(pick + 1);
        g.size = part_size[pick];
      end
      pending_grants.push_back(g);
    endfunction

    function void check_grant(logic ok, id_t id, size_t size);
      grant_t want;
      if (pending_grants.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending: ok=%0b id=%0d size=%0d",
                 $time, ok, id, size);
        return;
      end
      want = pending_grants.pop_front();
      if (ok !== want.ok) begin
        mismatches++;
        $display("%0t: ok expected %0b, actual %0b", $time, want.ok, ok);
      end
      if (id !== want.id) begin
        mismatches++;
        $display("%0t: granted_id expected %0d, actual %0d", $time, want.id, id);
      end
      if (size !== want.size) begin
        mismatches++;
        $display("%0t: granted_size expected %0d, actual %0d", $time, want.size, size);
      end
    endfunction

    function int outstanding();
      return pending_grants.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [SIZE_W-1:0]    request_size_i;
  logic [ID_W-1:0]      target_id_i;
  logic                 done_o;
  logic                 ok_o;
  logic [ID_W-1:0]      granted_id_o;
  logic [SIZE_W-1:0]    granted_size_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIZE_W-1:0]    cfg_data_i;

  partition_ledger ledger;
  int unsigned     cycles;

  fixed_partition_fit_allocator #(
    .NUM_PARTS(NUM_PARTS)
  ) dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .cmd_i,
    .request_size_i,
    .target_id_i,
    .done_o,
    .ok_o,
    .granted_id_o,
    .granted_size_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // 10 ns clock, low for the first half period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("fixed_partition_fit_allocator regression: fail");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, where the stimulus is
  // stable since it only moves on falling edges. A result and a new command
  // can share an edge; the result belongs to the older command, so it is
  // checked before the new command is noted. Configuration transfers update
  // the mirror at the edge where they happen.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        ledger.check_grant(ok_o, granted_id_o, granted_size_o);
      end
      if (start_i && !busy_o) begin
        ledger.note_request(cmd_e'(cmd_i), request_size_i, target_id_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ledger.set_size(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Issues one command. With probability idle_pct the sender first sits idle
  // with start low, so that start rises at every point of a busy period.
  // start stays high after the transfer until the next falling edge, where it
  // either carries the next command or drops; it is assigned once per edge.
  task automatic send_cmd(cmd_e cmd, size_t need, id_t tid, int unsigned idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 14)) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    cmd_i          <= cmd;
    request_size_i <= need;
    target_id_i    <= tid;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // One transfer on the configuration channel; valid stays up for a burst.
  task automatic write_size(logic [CFG_IDX_W-1:0] idx, size_t value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic close_cfg();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drops start, waits for every pending grant, then lets the scan pipeline
  // run dry before anything else touches the block.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (NUM_PARTS + 4) @(posedge clk_i);
  endtask

  // Partition sizes for each random phase: the extremes first, then mixes.
  function automatic size_t size_for(int unsigned mode, int i);
    case (mode)
      0: return 16'hFFFF;
      1: return 16'd1;
      2: return size_t'($urandom_range(0, 24));
      3: return size_t'($urandom_range(0, 65535));
      4: begin
        case ($urandom_range(0, 3))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'hFFFF;
          default: return size_t'($urandom);
        endcase
      end
      // Only the last partition stays present; all the others become absent.
      5: return (i == NUM_PARTS - 1) ? size_t'($urandom_range(1, 65535)) : 16'd0;
      default: return size_t'($urandom_range(1, 65535));
    endcase
  endfunction

  // Request sizes cluster on the configured sizes so that fits, near misses
  // and exact ties all occur; the rest are zero, small or fully random.
  function automatic size_t pick_request();
    int    k;
    size_t base;
    k    = $urandom_range(0, NUM_PARTS - 1);
    base = ledger.part_size[k];
    case ($urandom_range(0, 7))
      0, 1: return base;
      2: return base + 16'd1;
      3: return base - 16'd1;
      4: return 16'd0;
      5: return size_t'($urandom_range(0, 24));
      default: return size_t'($urandom);
    endcase
  endfunction

  // Frees mostly name a real partition; the rest draw any id, bad ones included.
  function automatic id_t pick_target();
    if ($urandom_range(99) < 85) return id_t'($urandom_range(1, NUM_PARTS));
    return id_t'($urandom_range(0, 15));
  endfunction

  function automatic cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 38) return CMD_FIRST_FIT;
    if (r < 70) return CMD_BEST_FIT;
    if (r < 95) return CMD_FREE;
    return CMD_UNUSED;
  endfunction

  initial begin
    // Sender idle percentage per random phase; zero gives back-to-back runs.
    int unsigned idle_pcts[RAND_PHASES] = '{0, 61, 0, 36, 61, 0, 36};
    int          failures;

    ledger         = new();
    cycles         = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    cmd_i          = CMD_FIRST_FIT;
    request_size_i = '0;
    target_id_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Out of reset every partition is absent, so everything fails.
    send_cmd(CMD_FIRST_FIT, 16'd1, 4'd0, 0);
    send_cmd(CMD_BEST_FIT, 16'd0, 4'd0, 0);
    send_cmd(CMD_FREE, 16'd0, 4'd1, 0);
    send_cmd(CMD_UNUSED, 16'd0, 4'd0, 0);
    wait_idle();

    // Partition 3 is absent; partitions 2 and 5 tie for best fit.
    write_size(4'd0, 16'd100);
    write_size(4'd1, 16'd50);
    write_size(4'd2, 16'd0);
    write_size(4'd3, 16'd200);
    write_size(4'd4, 16'd50);
    write_size(4'd5, 16'hFFFF);
    write_size(4'd6, 16'd1);
    write_size(4'd7, 16'd300);
    // Indexes past the last partition must be dropped.
    write_size(4'd8, 16'd7777);
    write_size(4'd15, 16'hFFFF);
    close_cfg();

    send_cmd(CMD_FIRST_FIT, 16'd0, 4'd0, 0);      // zero size takes the first
    send_cmd(CMD_BEST_FIT, 16'd50, 4'd0, 0);      // tie goes to partition 2
    send_cmd(CMD_BEST_FIT, 16'd50, 4'd0, 0);      // then partition 5
    send_cmd(CMD_FIRST_FIT, 16'hFFFF, 4'd0, 0);   // largest request fits once
    send_cmd(CMD_FIRST_FIT, 16'hFFFF, 4'd0, 0);
    send_cmd(CMD_BEST_FIT, 16'd1, 4'd0, 0);
    send_cmd(CMD_FIRST_FIT, 16'd300, 4'd0, 0);
    send_cmd(CMD_FREE, 16'd0, 4'd3, 0);           // absent partition
    send_cmd(CMD_FREE, 16'd0, 4'd0, 0);           // id zero never matches
    send_cmd(CMD_FREE, 16'd0, 4'd9, 0);
    send_cmd(CMD_FREE, 16'hFFFF, 4'd15, 0);
    send_cmd(CMD_FREE, 16'd0, 4'd2, 0);
    send_cmd(CMD_FREE, 16'd0, 4'd2, 0);           // freeing a free partition
    send_cmd(CMD_UNUSED, 16'hFFFF, 4'd15, 0);
    send_cmd(CMD_BEST_FIT, 16'd201, 4'd0, 0);     // nothing large enough
    send_cmd(CMD_BEST_FIT, 16'd150, 4'd0, 0);
    wait_idle();

    // Partition 1 is claimed; resizing it to zero hides it from every command.
    write_size(4'd0, 16'd0);
    close_cfg();
    send_cmd(CMD_FREE, 16'd0, 4'd1, 0);
    send_cmd(CMD_FIRST_FIT, 16'd0, 4'd0, 0);
    wait_idle();
    // Back with a new size, it is still claimed until it is freed.
    write_size(4'd0, 16'd40);
    close_cfg();
    send_cmd(CMD_FIRST_FIT, 16'd0, 4'd0, 0);
    send_cmd(CMD_FREE, 16'd0, 4'd1, 0);
    wait_idle();

    // Random phases: new sizes each time, free flags carried over.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        write_size(CFG_IDX_W'(i), size_for(ph, i));
      end
      write_size(CFG_IDX_W'($urandom_range(NUM_PARTS, 15)), size_t'($urandom));
      close_cfg();
      repeat (PHASE_ITEMS) begin
        send_cmd(pick_cmd(), pick_request(), pick_target(), idle_pcts[ph]);
      end
      wait_idle();
    end

    failures = ledger.mismatches + ledger.outstanding();
    if (failures == 0) begin
      $display("fixed_partition_fit_allocator regression: pass");
    end else begin
      $display("fixed_partition_fit_allocator regression: fail");
    end
    $finish;
  end

endmodule
